### rtl/uvs_pkg.sv
// Shared types, constants and series coefficients for the UV sphere grid point generator.
`default_nettype none

package uvs_pkg;

	localparam int CNT_W   = 9;
	localparam int IDX_W   = 16;
	localparam int COORD_W = 16;
	localparam int ADDR_W  = 3;

	// register select is byte address bit 2
	localparam logic REG_SECTOR_COUNT = 1'b0;
	localparam logic REG_STACK_COUNT  = 1'b1;

	localparam logic [CNT_W-1:0] SECTOR_RESET = 9'd32;
	localparam logic [CNT_W-1:0] STACK_RESET  = 9'd16;

	localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// reciprocals ceil(2^(30+l)/c) with 2^l >= c, exact for 30-bit dividends
	localparam logic [30:0] RCP_S1 = 31'(((64'd1 << 33) + 64'd5)   / 64'd6);
	localparam logic [30:0] RCP_S2 = 31'(((64'd1 << 35) + 64'd19)  / 64'd20);
	localparam logic [30:0] RCP_S3 = 31'(((64'd1 << 36) + 64'd41)  / 64'd42);
	localparam logic [30:0] RCP_S4 = 31'(((64'd1 << 37) + 64'd71)  / 64'd72);
	localparam logic [30:0] RCP_S5 = 31'(((64'd1 << 37) + 64'd109) / 64'd110);
	localparam logic [30:0] RCP_S6 = 31'(((64'd1 << 38) + 64'd155) / 64'd156);
	localparam logic [30:0] RCP_C1 = 31'(((64'd1 << 31) + 64'd1)   / 64'd2);
	localparam logic [30:0] RCP_C2 = 31'(((64'd1 << 34) + 64'd11)  / 64'd12);
	localparam logic [30:0] RCP_C3 = 31'(((64'd1 << 35) + 64'd29)  / 64'd30);
	localparam logic [30:0] RCP_C4 = 31'(((64'd1 << 36) + 64'd55)  / 64'd56);
	localparam logic [30:0] RCP_C5 = 31'(((64'd1 << 37) + 64'd89)  / 64'd90);
	localparam logic [30:0] RCP_C6 = 31'(((64'd1 << 38) + 64'd131) / 64'd132);

	function automatic logic [30:0] sin_rcp(input int k);
		case (k)
			1: return RCP_S1;
			2: return RCP_S2;
			3: return RCP_S3;
			4: return RCP_S4;
			5: return RCP_S5;
			default: return RCP_S6;
		endcase
	endfunction

	function automatic int sin_shift(input int k);
		case (k)
			1: return 33;
			2: return 35;
			3: return 36;
			4: return 37;
			5: return 37;
			default: return 38;
		endcase
	endfunction

	function automatic logic [30:0] cos_rcp(input int k);
		case (k)
			1: return RCP_C1;
			2: return RCP_C2;
			3: return RCP_C3;
			4: return RCP_C4;
			5: return RCP_C5;
			default: return RCP_C6;
		endcase
	endfunction

	function automatic int cos_shift(input int k);
		case (k)
			1: return 31;
			2: return 34;
			3: return 35;
			4: return 36;
			5: return 37;
			default: return 38;
		endcase
	endfunction

	typedef struct packed {
		logic [7:0] stack_row;
		logic [7:0] sector_col;
	} req_t;

	typedef struct packed {
		logic             upper_tri_valid;
		logic [IDX_W-1:0] upper_tri_a;
		logic [IDX_W-1:0] upper_tri_b;
		logic [IDX_W-1:0] upper_tri_c;
		logic             lower_tri_valid;
		logic [IDX_W-1:0] lower_tri_a;
		logic [IDX_W-1:0] lower_tri_b;
		logic [IDX_W-1:0] lower_tri_c;
	} tri_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      upper_tri_valid;
		logic [IDX_W-1:0]          upper_tri_a;
		logic [IDX_W-1:0]          upper_tri_b;
		logic [IDX_W-1:0]          upper_tri_c;
		logic                      lower_tri_valid;
		logic [IDX_W-1:0]          lower_tri_a;
		logic [IDX_W-1:0]          lower_tri_b;
		logic [IDX_W-1:0]          lower_tri_c;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/uvs_recip.sv
// Serial restoring divider: quotient and remainder of 2^K by a count.
`default_nettype none

module uvs_recip #(
	parameter int K = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [uvs_pkg::CNT_W-1:0] divisor,
	output logic                          busy,
	output logic [31:0]                   quo,
	output logic [uvs_pkg::CNT_W-1:0]     rem
);

	localparam int CW = $clog2(K + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     quo_q;
	logic [uvs_pkg::CNT_W-1:0] rem_q;
	logic [uvs_pkg::CNT_W:0]   trial;
	logic                      ge;

	// the dividend is a one followed by K zeros
	assign trial = {rem_q, cnt_q == CW'(K)};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(K);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? uvs_pkg::CNT_W'(trial - {1'b0, divisor}) : trial[uvs_pkg::CNT_W-1:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### rtl/uvs_trig.sv
// Pipelined first-octant Taylor sine/cosine of a 32-bit phase, Q30 results.
`default_nettype none

module uvs_trig (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] phase,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);

	localparam int TERMS = 6;

	logic [29:0] r_fold;
	logic [62:0] x_prod;
	logic [29:0] x_s1;
	logic [2:0]  oct_s1;
	logic [60:0] sq;

	logic [30:0]        ts_b  [0:TERMS];
	logic [30:0]        tc_b  [0:TERMS];
	logic signed [31:0] ss_b  [0:TERMS];
	logic signed [31:0] cc_b  [0:TERMS];
	logic [29:0]        x2_b  [0:TERMS];
	logic [2:0]         oct_b [0:TERMS];

	logic [29:0]        vs_a  [1:TERMS];
	logic [29:0]        vc_a  [1:TERMS];
	logic signed [31:0] ss_a  [1:TERMS];
	logic signed [31:0] cc_a  [1:TERMS];
	logic [29:0]        x2_a  [1:TERMS];
	logic [2:0]         oct_a [1:TERMS];

	logic signed [31:0] sn_c, cs_c;

	// odd octants run backward from their far edge
	assign r_fold = phase[29] ? 30'(30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
	assign x_prod = 63'(r_fold) * 63'(uvs_pkg::PI_Q30) + (63'd1 << 30);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_prod[60:31];
			oct_s1 <= phase[31:29];
		end
	end

	assign sq = 61'(x_s1) * 61'(x_s1) + (61'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			x2_b[0]  <= sq[59:30];
			ts_b[0]  <= {1'b0, x_s1};
			tc_b[0]  <= uvs_pkg::ONE_Q30;
			ss_b[0]  <= $signed({2'b00, x_s1});
			cc_b[0]  <= $signed({1'b0, uvs_pkg::ONE_Q30});
			oct_b[0] <= oct_s1;
		end
	end

	for (genvar k = 1; k <= TERMS; k++) begin : g_term
		localparam int  SSH = uvs_pkg::sin_shift(k);
		localparam int  CSH = uvs_pkg::cos_shift(k);
		localparam bit  SUB = (k % 2) == 1;

		logic [60:0] ps, pc, ms, mc;
		logic [30:0] ts_n, tc_n;

		assign ps = 61'(ts_b[k-1]) * 61'(x2_b[k-1]);
		assign pc = 61'(tc_b[k-1]) * 61'(x2_b[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				vs_a[k]  <= ps[59:30];
				vc_a[k]  <= pc[59:30];
				ss_a[k]  <= ss_b[k-1];
				cc_a[k]  <= cc_b[k-1];
				x2_a[k]  <= x2_b[k-1];
				oct_a[k] <= oct_b[k-1];
			end
		end

		// divide by the term's constant through its exact reciprocal
		assign ms   = 61'(vs_a[k]) * 61'(uvs_pkg::sin_rcp(k));
		assign mc   = 61'(vc_a[k]) * 61'(uvs_pkg::cos_rcp(k));
		assign ts_n = 31'(ms >> SSH);
		assign tc_n = 31'(mc >> CSH);

		always_ff @(posedge clk) begin
			if (en) begin
				ts_b[k]  <= ts_n;
				tc_b[k]  <= tc_n;
				ss_b[k]  <= SUB ? ss_a[k] - $signed({1'b0, ts_n}) : ss_a[k] + $signed({1'b0, ts_n});
				cc_b[k]  <= SUB ? cc_a[k] - $signed({1'b0, tc_n}) : cc_a[k] + $signed({1'b0, tc_n});
				x2_b[k]  <= x2_a[k];
				oct_b[k] <= oct_a[k];
			end
		end
	end

	always_comb begin
		case (oct_b[TERMS])
			3'd0: begin sn_c =  ss_b[TERMS]; cs_c =  cc_b[TERMS]; end
			3'd1: begin sn_c =  cc_b[TERMS]; cs_c =  ss_b[TERMS]; end
			3'd2: begin sn_c =  cc_b[TERMS]; cs_c = -ss_b[TERMS]; end
			3'd3: begin sn_c =  ss_b[TERMS]; cs_c = -cc_b[TERMS]; end
			3'd4: begin sn_c = -ss_b[TERMS]; cs_c = -cc_b[TERMS]; end
			3'd5: begin sn_c = -cc_b[TERMS]; cs_c = -ss_b[TERMS]; end
			3'd6: begin sn_c = -cc_b[TERMS]; cs_c =  ss_b[TERMS]; end
			default: begin sn_c = -ss_b[TERMS]; cs_c = cc_b[TERMS]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine   <= sn_c;
			cosine <= cs_c;
		end
	end

endmodule

`default_nettype wire

### rtl/uv_sphere_vertex_and_triangle_gen_core.sv
// Throughput: one request per cycle while in_stall is low, through the 24-stage
// pipeline whose longest part is the 15-stage Taylor sine/cosine unit; out_stall
// freezes all stages. Reset: counts go to 32 sectors and 16 stacks, the pipeline
// empties, and the two reciprocal dividers run with in_stall high; each register
// write repeats that divider pass.
`default_nettype none

module uv_sphere_vertex_and_triangle_gen_core #(
	parameter int MAX_SECTORS     = 256,
	parameter int MAX_STACKS      = 256,
	parameter int COORD_FRAC_BITS = 15
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [uvs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire uvs_pkg::req_t               in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output uvs_pkg::rsp_t                    out_data
);

	localparam int LAST  = 24;
	localparam int DIVST = 4;
	localparam int SH_XZ = 60 - COORD_FRAC_BITS;
	localparam int SH_Y  = 30 - COORD_FRAC_BITS;
	localparam int CW    = uvs_pkg::CNT_W;
	localparam int IW    = uvs_pkg::IDX_W;

	typedef struct packed {
		logic [15:0]   num;
		logic [CW-1:0] rem;
		logic [15:0]   quo;
	} dstep_t;

	function automatic dstep_t div4(input dstep_t d, input logic [CW-1:0] dv);
		dstep_t    r;
		logic [CW:0] t;
		r = d;
		for (int i = 0; i < 4; i++) begin
			t     = {r.rem, r.num[15]};
			r.num = {r.num[14:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				r.rem = CW'(t - {1'b0, dv});
				r.quo = {r.quo[14:0], 1'b1};
			end else begin
				r.rem = t[CW-1:0];
				r.quo = {r.quo[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(input logic neg, input logic [61:0] m);
		if (neg) begin
			return (m > 62'd32768) ? 16'h8000 : 16'(62'd0 - m);
		end
		return (m > 62'd32767) ? 16'h7FFF : m[15:0];
	endfunction

	// configuration registers
	logic [CW-1:0] sector_q, stack_q;
	logic          pend_q;
	logic          cfg_wr;
	logic [CW-1:0] ns_c, nt_c, d_c;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= uvs_pkg::SECTOR_RESET;
			stack_q  <= uvs_pkg::STACK_RESET;
			pend_q   <= 1'b1;
		end else begin
			pend_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (paddr[2])
					uvs_pkg::REG_SECTOR_COUNT: sector_q <= pwdata[CW-1:0];
					uvs_pkg::REG_STACK_COUNT:  stack_q  <= pwdata[CW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			uvs_pkg::REG_SECTOR_COUNT: prdata = 32'(sector_q);
			uvs_pkg::REG_STACK_COUNT:  prdata = 32'(stack_q);
			default:                   prdata = '0;
		endcase
	end

	assign ns_c = (sector_q < 9'd3) ? 9'd3 :
	              (32'(sector_q) > MAX_SECTORS) ? CW'(MAX_SECTORS) : sector_q;
	assign nt_c = (stack_q < 9'd3) ? 9'd3 :
	              (32'(stack_q) > MAX_STACKS) ? CW'(MAX_STACKS) : stack_q;
	assign d_c  = nt_c - 9'd1;

	// reciprocal dividers: 2^32 / sectors and 2^31 / (stacks - 1)
	logic          lon_busy, lat_busy;
	logic [31:0]   lon_quo, lat_quo;
	logic [CW-1:0] lon_rem, lat_rem;

	uvs_recip #(.K(32)) u_rcp_lon (
		.clk(clk), .arst_n(arst_n), .start(pend_q), .divisor(ns_c),
		.busy(lon_busy), .quo(lon_quo), .rem(lon_rem)
	);

	uvs_recip #(.K(31)) u_rcp_lat (
		.clk(clk), .arst_n(arst_n), .start(pend_q), .divisor(d_c),
		.busy(lat_busy), .quo(lat_quo), .rem(lat_rem)
	);

	// pipeline control
	logic            en, accept;
	logic [LAST:1]   valid_s;

	assign en       = !(valid_s[LAST] && out_stall);
	assign in_stall = pend_q || lon_busy || lat_busy || !en;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[LAST-1:1], accept};
		end
	end

	// stage 1: integer parts of the phases, remainder numerators, row base index
	logic [31:0]   lat_hi_s [1:DIVST+1];
	logic [31:0]   lon_hi_s [1:DIVST+1];
	dstep_t        lat_dv_s [1:DIVST+1];
	dstep_t        lon_dv_s [1:DIVST+1];
	logic [7:0]    row_s1, col_s1;
	logic [IW-1:0] k1_s1;
	logic [16:0]   lat_n_c, lon_n_c;

	assign lat_n_c = 17'(in_data.stack_row) * 17'(lat_rem) + 17'(d_c >> 1);
	assign lon_n_c = 17'(in_data.sector_col) * 17'(lon_rem) + 17'(ns_c >> 1);

	// the numerator's top bit never yields a quotient bit: preload it as remainder
	always_ff @(posedge clk) begin
		if (en) begin
			lat_hi_s[1] <= 32'({24'b0, in_data.stack_row} * lat_quo);
			lon_hi_s[1] <= 32'({24'b0, in_data.sector_col} * lon_quo);
			lat_dv_s[1] <= '{num: lat_n_c[15:0], rem: CW'(lat_n_c[16]), quo: '0};
			lon_dv_s[1] <= '{num: lon_n_c[15:0], rem: CW'(lon_n_c[16]), quo: '0};
			row_s1      <= in_data.stack_row;
			col_s1      <= in_data.sector_col;
			k1_s1       <= IW'(17'(in_data.stack_row) * 17'(ns_c));
		end
	end

	// stages 2..5: four quotient bits per stage
	for (genvar j = 1; j <= DIVST; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				lat_dv_s[j+1] <= div4(lat_dv_s[j], d_c);
				lon_dv_s[j+1] <= div4(lon_dv_s[j], ns_c);
				lat_hi_s[j+1] <= lat_hi_s[j];
				lon_hi_s[j+1] <= lon_hi_s[j];
			end
		end
	end

	// stage 2: triangle indices, then carried to the output
	uvs_pkg::tri_t tri_s [2:LAST];
	uvs_pkg::tri_t tri_c;
	logic [IW-1:0] k2_c, n1_c, n2_c;
	logic          last_c, ing_c;

	always_comb begin
		k2_c   = k1_s1 + IW'(ns_c);
		last_c = (9'(col_s1) == ns_c - 9'd1);
		n1_c   = last_c ? k1_s1 : k1_s1 + IW'(col_s1) + 16'd1;
		n2_c   = last_c ? k2_c  : k2_c  + IW'(col_s1) + 16'd1;
		ing_c  = (9'(col_s1) < ns_c) && (10'(row_s1) + 10'd1 < 10'(nt_c));
		tri_c  = '0;
		if (ing_c && row_s1 != 8'd0) begin
			tri_c.upper_tri_valid = 1'b1;
			tri_c.upper_tri_a     = k1_s1 + IW'(col_s1);
			tri_c.upper_tri_b     = k2_c + IW'(col_s1);
			tri_c.upper_tri_c     = n1_c;
		end
		if (ing_c && (10'(row_s1) + 10'd2 < 10'(nt_c))) begin
			tri_c.lower_tri_valid = 1'b1;
			tri_c.lower_tri_a     = n1_c;
			tri_c.lower_tri_b     = k2_c + IW'(col_s1);
			tri_c.lower_tri_c     = n2_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s[2] <= tri_c;
			for (int i = 3; i <= LAST; i++) begin
				tri_s[i] <= tri_s[i-1];
			end
		end
	end

	// stage 6: phases
	logic [31:0] lat_p_s6, lon_p_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			lat_p_s6 <= uvs_pkg::QUARTER_TURN - (lat_hi_s[DIVST+1] + 32'(lat_dv_s[DIVST+1].quo));
			lon_p_s6 <= lon_hi_s[DIVST+1] + 32'(lon_dv_s[DIVST+1].quo);
		end
	end

	// stages 7..21: sine and cosine
	logic signed [31:0] slat_s21, clat_s21, slon_s21, clon_s21;

	uvs_trig u_trig_lat (
		.clk(clk), .en(en), .phase(lat_p_s6), .sine(slat_s21), .cosine(clat_s21)
	);

	uvs_trig u_trig_lon (
		.clk(clk), .en(en), .phase(lon_p_s6), .sine(slon_s21), .cosine(clon_s21)
	);

	// stages 22..24: products, magnitudes, round and saturate
	logic signed [63:0] px_s22, pz_s22;
	logic signed [31:0] py_s22;
	logic               nx_s23, ny_s23, nz_s23;
	logic [60:0]        mx_s23, mz_s23;
	logic [30:0]        my_s23;
	logic [61:0]        rx_c, ry_c, rz_c;
	logic [15:0]        pos_x_s24, pos_y_s24, pos_z_s24;
	logic [63:0]        ax_c, az_c;
	logic [31:0]        ay_c;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s22 <= 64'(clon_s21) * 64'(clat_s21);
			pz_s22 <= 64'(slon_s21) * 64'(clat_s21);
			py_s22 <= slat_s21;
		end
	end

	assign ax_c = px_s22[63] ? 64'(-px_s22) : 64'(px_s22);
	assign az_c = pz_s22[63] ? 64'(-pz_s22) : 64'(pz_s22);
	assign ay_c = py_s22[31] ? 32'(-py_s22) : 32'(py_s22);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s23 <= px_s22[63];
			nz_s23 <= pz_s22[63];
			ny_s23 <= py_s22[31];
			mx_s23 <= ax_c[60:0];
			mz_s23 <= az_c[60:0];
			my_s23 <= ay_c[30:0];
		end
	end

	assign rx_c = (62'(mx_s23) + (62'd1 << (SH_XZ - 1))) >> SH_XZ;
	assign rz_c = (62'(mz_s23) + (62'd1 << (SH_XZ - 1))) >> SH_XZ;

	if (SH_Y > 0) begin : g_ry
		assign ry_c = (62'(my_s23) + (62'd1 << (SH_Y - 1))) >> SH_Y;
	end else begin : g_ry_none
		assign ry_c = 62'(my_s23);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x_s24 <= sat16(nx_s23, rx_c);
			pos_y_s24 <= sat16(ny_s23, ry_c);
			pos_z_s24 <= sat16(nz_s23, rz_c);
		end
	end

	assign out_valid = valid_s[LAST];

	always_comb begin
		out_data.pos_x           = $signed(pos_x_s24);
		out_data.pos_y           = $signed(pos_y_s24);
		out_data.pos_z           = $signed(pos_z_s24);
		out_data.upper_tri_valid = tri_s[LAST].upper_tri_valid;
		out_data.upper_tri_a     = tri_s[LAST].upper_tri_a;
		out_data.upper_tri_b     = tri_s[LAST].upper_tri_b;
		out_data.upper_tri_c     = tri_s[LAST].upper_tri_c;
		out_data.lower_tri_valid = tri_s[LAST].lower_tri_valid;
		out_data.lower_tri_a     = tri_s[LAST].lower_tri_a;
		out_data.lower_tri_b     = tri_s[LAST].lower_tri_b;
		out_data.lower_tri_c     = tri_s[LAST].lower_tri_c;
	end

	a_no_accept_while_recip: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q || lon_busy || lat_busy) |-> in_stall)
		else $error("request accepted while reciprocals are being computed");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s[1])
		else $error("accepted request did not enter the pipeline");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[LAST] && out_stall) |=> $stable(valid_s))
		else $error("pipeline moved while the result was stalled");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.upper_tri_valid) |->
		(out_data.upper_tri_a == '0 && out_data.upper_tri_b == '0 &&
		 out_data.upper_tri_c == '0))
		else $error("dropped upper triangle carries nonzero indices");

endmodule

`default_nettype wire

### sim/tb_uv_sphere_vertex_and_triangle_gen_core.sv
// Self-checking testbench for the UV sphere grid point generator core.
`default_nettype none

module tb_uv_sphere_vertex_and_triangle_gen_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SECT  = 256;
	localparam int MAX_STK   = 256;
	localparam int FRAC      = 15;
	localparam int CYC_LIMIT = 2000000;
	localparam int IDLE_WAIT = 40;
	localparam logic [63:0] PI_RAD_Q30 = 64'hC90FDAA2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [uvs_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	uvs_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	uvs_pkg::rsp_t out_data;

	uv_sphere_vertex_and_triangle_gen_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// local copy of the count registers
	logic [uvs_pkg::CNT_W-1:0] sectors_reg = uvs_pkg::SECTOR_RESET;
	logic [uvs_pkg::CNT_W-1:0] stacks_reg  = uvs_pkg::STACK_RESET;

	uvs_pkg::rsp_t point_q[$];
	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_tog = 1'b0;
	int unsigned cycles = 0;

	function automatic void octant_sincos(input longint x, output longint s, output longint c);
		longint x2, ts, tc;
		x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
		ts = x; tc = 64'sd1 <<< 30; s = x; c = 64'sd1 <<< 30;
		for (int k = 1; k <= 6; k++) begin
			ts = ((ts * x2) >>> 30) / ((2 * k) * (2 * k + 1));
			tc = ((tc * x2) >>> 30) / ((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				s -= ts; c -= tc;
			end else begin
				s += ts; c += tc;
			end
		end
	endfunction

	function automatic void phase_sincos(input logic [31:0] p, output longint sn, output longint cs);
		logic [2:0] oct;
		longint unsigned r;
		longint x, s, c;
		oct = p[31:29];
		r = {35'd0, p[28:0]};
		if (oct[0])
			r = (64'd1 << 29) - r;
		x = longint'((r * PI_RAD_Q30 + (64'd1 << 30)) >> 31);
		octant_sincos(x, s, c);
		case (oct)
			3'd0: begin sn = s; cs = c; end
			3'd1: begin sn = c; cs = s; end
			3'd2: begin sn = c; cs = -s; end
			3'd3: begin sn = s; cs = -c; end
			3'd4: begin sn = -s; cs = -c; end
			3'd5: begin sn = -c; cs = -s; end
			3'd6: begin sn = -c; cs = s; end
			default: begin sn = -s; cs = c; end
		endcase
	endfunction

	function automatic logic [15:0] round_sat(input longint v, input int shift);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		m = (m + (64'd1 << (shift - 1))) >> shift;
		if (v < 0) begin
			if (m > 32768) m = 32768;
			return 16'(-m);
		end
		if (m > 32767) m = 32767;
		return 16'(m);
	endfunction

	function automatic uvs_pkg::rsp_t predict_point(input uvs_pkg::req_t rq);
		uvs_pkg::rsp_t r;
		longint unsigned ns, nt, row, col, d, k1, k2, n1, n2;
		logic [31:0] lat_p, lon_p;
		longint slat, clat, slon, clon;
		logic in_grid;
		ns = sectors_reg < 3 ? 3 : (sectors_reg > MAX_SECT ? MAX_SECT : sectors_reg);
		nt = stacks_reg < 3 ? 3 : (stacks_reg > MAX_STK ? MAX_STK : stacks_reg);
		row = rq.stack_row;
		col = rq.sector_col;
		d = nt - 1;
		lat_p = 32'((64'd1 << 30) - (((row << 31) + (d >> 1)) / d));
		lon_p = 32'(((col << 32) + (ns >> 1)) / ns);
		phase_sincos(lat_p, slat, clat);
		phase_sincos(lon_p, slon, clon);
		r = '0;
		r.pos_x = round_sat(clon * clat, 60 - FRAC);
		r.pos_y = round_sat(slat, 30 - FRAC);
		r.pos_z = round_sat(slon * clat, 60 - FRAC);
		in_grid = (col < ns) && (row + 1 < nt);
		k1 = row * ns;
		k2 = k1 + ns;
		n1 = (col == ns - 1) ? k1 : k1 + col + 1;
		n2 = (col == ns - 1) ? k2 : k2 + col + 1;
		if (in_grid && row != 0) begin
			r.upper_tri_valid = 1'b1;
			r.upper_tri_a = 16'(k1 + col);
			r.upper_tri_b = 16'(k2 + col);
			r.upper_tri_c = 16'(n1);
		end
		if (in_grid && row + 2 < nt) begin
			r.lower_tri_valid = 1'b1;
			r.lower_tri_a = 16'(n1);
			r.lower_tri_b = 16'(k2 + col);
			r.lower_tri_c = 16'(n2);
		end
		return r;
	endfunction

	// receiver: random stall plus a long hold-off when hold_tog flips
	always @(posedge clk) begin
		static int hold_left = 0;
		static logic hold_seen = 1'b0;
		if (hold_tog != hold_seen) begin
			hold_seen = hold_tog;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		uvs_pkg::rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (point_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				want = point_q.pop_front();
				if (out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
				    out_data.pos_z !== want.pos_z ||
				    out_data.upper_tri_valid !== want.upper_tri_valid ||
				    out_data.upper_tri_a !== want.upper_tri_a ||
				    out_data.upper_tri_b !== want.upper_tri_b ||
				    out_data.upper_tri_c !== want.upper_tri_c ||
				    out_data.lower_tri_valid !== want.lower_tri_valid ||
				    out_data.lower_tri_a !== want.lower_tri_a ||
				    out_data.lower_tri_b !== want.lower_tri_b ||
				    out_data.lower_tri_c !== want.lower_tri_c) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch (sect %0d stk %0d)\n  exp %p\n  got %p",
							sectors_reg, stacks_reg, want, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("tb_uv_sphere_vertex_and_triangle_gen_core failed");
			$finish;
		end
	end

	task automatic send_point(input int row, input int col);
		uvs_pkg::req_t rq;
		rq.stack_row = 8'(row);
		rq.sector_col = 8'(col);
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (in_stall);
		point_q.insert(point_q.size(), predict_point(rq));
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			in_data <= '0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (point_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_count(input logic sel, input int value);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {sel, 2'b00}; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == uvs_pkg::REG_SECTOR_COUNT) sectors_reg = 9'(value);
		else stacks_reg = 9'(value);
	endtask

	task automatic set_counts(input int sect, input int stk);
		write_count(uvs_pkg::REG_SECTOR_COUNT, sect);
		write_count(uvs_pkg::REG_STACK_COUNT, stk);
	endtask

	// poles, last rows, ring wrap and out-of-grid points at the default counts, then at 256 sectors and stacks
	task automatic test_directed();
		int rows[6] = '{0, 1, 14, 15, 16, 255};
		int cols[3] = '{0, 31, 32};
		foreach (rows[i]) foreach (cols[j]) send_point(rows[i], cols[j]);
		send_point(7, 255);
		set_counts(256, 256);
		send_point(254, 255);
		send_point(255, 255);
		send_point(0, 128);
		send_point(128, 0);
		send_point(170, 85);
	endtask

	// counts out of range and at the lower limit, including the extremes that clamp
	task automatic test_count_clamp();
		int sect[5] = '{0, 2, 3, 257, 511};
		int stk[5]  = '{1, 3, 2, 300, 511};
		foreach (sect[i]) begin
			set_counts(sect[i], stk[i]);
			send_point(0, 2);
			send_point(1, 0);
			send_point(2, 3);
			send_point(255, 255);
		end
	endtask

	task automatic random_batch(input int n);
		int ns, nt;
		ns = sectors_reg < 3 ? 3 : (sectors_reg > MAX_SECT ? MAX_SECT : sectors_reg);
		nt = stacks_reg < 3 ? 3 : (stacks_reg > MAX_STK ? MAX_STK : stacks_reg);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				send_point($urandom_range(255), $urandom_range(255));
			else
				send_point($urandom_range(nt - 1), $urandom_range(ns - 1));
		end
	endtask

	task automatic test_random();
		int sect[6] = '{32, 3, 256, 7, 100, 256};
		int stk[6]  = '{16, 3, 256, 200, 5, 9};
		foreach (sect[i]) begin
			set_counts(sect[i], stk[i]);
			tx_idle_pct = 12; rx_idle_pct = 45;
			random_batch(50);
			tx_idle_pct = 45; rx_idle_pct = 12;
			random_batch(50);
			tx_idle_pct = 0; rx_idle_pct = 0;
			random_batch(50);
		end
	endtask

	// hold the output off long enough for the pipeline to back up into in_stall
	task automatic test_backpressure();
		set_counts(256, 256);
		tx_idle_pct = 0; rx_idle_pct = 0;
		hold_tog <= ~hold_tog;
		random_batch(60);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_clamp();
		test_random();
		test_backpressure();
		drain();
		if (mismatches == 0 && point_q.size() == 0)
			$display("tb_uv_sphere_vertex_and_triangle_gen_core passed");
		else
			$display("tb_uv_sphere_vertex_and_triangle_gen_core failed");
		$finish;
	end

endmodule

`default_nettype wire
